/* rtl/fcw_pkg.sv */
// Package with the shared types, constants and coefficient table of the face curvature weight block.
package fcw_pkg;

	localparam int unsigned NEIGHBOURS_DEF = 3;
	localparam logic [15:0] GAIN_RESET = 16'd2000;
	localparam logic [28:0] ONE_Q28 = 29'd268435456;
	localparam logic [29:0] PI_Q28 = 30'd843314857;
	localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;
	localparam logic [16:0] ONE_Q16 = 17'h1_0000;
	localparam logic [5:0] SQRT_STEPS = 6'd33;
	localparam logic [5:0] DIV_STEPS = 6'd34;
	localparam logic [2:0] ADDR_GAIN = 3'd0;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD_OWN,
		OP_CAPTURE,
		OP_SQUARE,
		OP_SQSUM,
		OP_DIST_START,
		OP_DIST_DONE,
		OP_HMUL,
		OP_HADD,
		OP_ACOS_START,
		OP_ACOS_DONE,
		OP_ACOS_MUL,
		OP_ACOS_FIN,
		OP_DIV_START,
		OP_DIV_DONE,
		OP_ACCUM
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] idx;
		logic       wmul;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic iter_done;
		logic dist_zero;
		logic last;
		logic out_free;
	} status_t;

	function automatic logic signed [31:0] acos_coef(input logic [1:0] idx);
		case (idx)
			2'd0:    acos_coef = 32'sd19934285;
			2'd1:    acos_coef = -32'sd56939026;
			2'd2:    acos_coef = 32'sd421639302;
			default: acos_coef = -32'sd5027608;
		endcase
	endfunction

endpackage

/* rtl/face_curvature_weight.sv */
// Top level of the face curvature weight block with its configuration register.
//
// Input stream s_*: tuser carries func (0 loads the own face, 1 brings one
// neighbour face); tdata carries cx, cy, cz, nx, ny, nz from the lowest bit up.
// Output stream m_*: tdata carries weight, tuser carries saturated. One result
// follows every NEIGHBOURS-th neighbour transfer (the third by default); own-face
// and other neighbour transfers give none.
// An own-face transfer is stored directly. A neighbour transfer uses the shared
// bit-serial unit for the distance root, the arccosine root and the term
// division, with sequencing, multiplies and handover between them; one whose
// centroids coincide skips the arccosine and the division. The last neighbour
// of a round also forms the weight.
// A new transfer is taken only once the previous item is finished.
// The result sits in an output register, so the next item is accepted while it
// waits; a stalled receiver holds back only the following result.
// Reset clears the own face, the running sum and count, and sets the gain to
// 2000. The gain register lies at byte address 0 of the APB port.
module face_curvature_weight
	import fcw_pkg::*;
#(
	parameter int unsigned NEIGHBOURS = NEIGHBOURS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // cx, cy, cz, nx, ny, nz
	input  logic [0:0]   s_tuser,  // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,  // weight
	output logic [0:0]   m_tuser,  // saturated
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [15:0] gain_q;
	cmd_t        cmd;
	status_t     status;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_GAIN) ? {16'd0, gain_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gain_q <= GAIN_RESET;
		else if (psel && penable && pwrite && !paddr[2])
			gain_q <= pwdata[15:0];
	end

	fcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_func  (s_tuser[0]),
		.status   (status),
		.cmd      (cmd)
	);

	fcw_datapath #(
		.NEIGHBOURS (NEIGHBOURS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_data    (s_tdata),
		.gain       (gain_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_weight (m_tdata),
		.out_sat    (m_tuser[0])
	);

endmodule

/* rtl/fcw_iter.sv */
// Shared iterative unit: restoring square root and restoring division, one bit per cycle.
module fcw_iter
	import fcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        mode_div,
	input  logic [65:0] radicand,
	input  logic [33:0] dividend,
	input  logic [32:0] divisor,
	output logic        done,
	output logic [33:0] result
);

	logic        busy_q;
	logic        done_q;
	logic        div_q;
	logic [5:0]  cnt_q;
	logic [65:0] x_q;
	logic [35:0] rem_q;
	logic [33:0] res_q;
	logic [32:0] dvs_q;
	logic [35:0] rem_sh;
	logic [35:0] cmp;
	logic        ge;

	always_comb begin
		if (div_q) begin
			rem_sh = {rem_q[34:0], x_q[65]};
			cmp = {3'b000, dvs_q};
		end else begin
			rem_sh = {rem_q[33:0], x_q[65:64]};
			cmp = {1'b0, res_q[32:0], 2'b01};
		end
		ge = (rem_sh >= cmp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= mode_div ? DIV_STEPS : SQRT_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= mode_div;
			x_q <= mode_div ? {dividend, 32'd0} : radicand;
			dvs_q <= divisor;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - cmp : rem_sh;
			res_q <= {res_q[32:0], ge};
			x_q <= div_q ? {x_q[64:0], 1'b0} : {x_q[63:0], 2'b00};
		end
	end

	assign done = done_q;
	assign result = res_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("iterative unit started while busy");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("iterative unit done while still busy");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> cnt_q != 6'd0)
		else $error("iterative unit busy with an empty count");

endmodule

/* rtl/fcw_datapath.sv */
// Datapath: face registers, distance, dot product, arccosine, term division and weight output.
module fcw_datapath
	import fcw_pkg::*;
#(
	parameter int unsigned NEIGHBOURS = NEIGHBOURS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output status_t      status,
	input  logic [143:0] in_data,
	input  logic [15:0]  gain,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [31:0]  out_weight,
	output logic         out_sat
);

	logic signed [31:0] own_c_q [3];
	logic signed [15:0] own_n_q [3];
	logic signed [31:0] nb_c_q [3];
	logic signed [15:0] nb_n_q [3];
	logic [65:0]        sq_q;
	logic [65:0]        sum_q;
	logic               dot_neg_q;
	logic [28:0]        u_q;
	logic [32:0]        dist_q;
	logic signed [31:0] p_q;
	logic signed [61:0] hprod_q;
	logic [28:0]        s_q;
	logic [59:0]        aprod_q;
	logic [29:0]        ac_q;
	logic [31:0]        term_q;
	logic [47:0]        csum_q;
	logic [1:0]         count_q;
	logic               clip_q;
	logic [63:0]        wprod_q;
	logic               out_valid_q;
	logic [31:0]        out_weight_q;
	logic               out_sat_q;

	logic signed [32:0] diff;
	logic [32:0]        dabs;
	logic signed [31:0] np0, np1, np2;
	logic signed [33:0] dot;
	logic signed [61:0] hshift;
	logic signed [31:0] p_next;
	logic [31:0]        a_val;
	logic [64:0]        wsum;
	logic               iter_start;
	logic               iter_div;
	logic               iter_done;
	logic [33:0]        iter_res;
	logic [65:0]        radicand;

	always_comb begin
		diff = 33'(own_c_q[cmd.idx]) - 33'(nb_c_q[cmd.idx]);
		dabs = diff[32] ? 33'(-diff) : 33'(diff);
		np0 = own_n_q[0] * nb_n_q[0];
		np1 = own_n_q[1] * nb_n_q[1];
		np2 = own_n_q[2] * nb_n_q[2];
		dot = 34'(np0) + 34'(np1) + 34'(np2);
		hshift = hprod_q >>> 28;
		p_next = 32'(hshift) + acos_coef(cmd.idx);
		a_val = aprod_q[59:28];
		wsum = {1'b0, wprod_q} + 65'(ONE_Q16);
		iter_start = (cmd.op == OP_DIST_START) || (cmd.op == OP_ACOS_START)
			|| (cmd.op == OP_DIV_START);
		iter_div = (cmd.op == OP_DIV_START);
		if (cmd.op == OP_DIST_START)
			radicand = sum_q;
		else
			radicand = {9'd0, ONE_Q28 - u_q, 28'd0};
	end

	fcw_iter u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (iter_start),
		.mode_div (iter_div),
		.radicand (radicand),
		.dividend ({ac_q, 4'd0}),
		.divisor  (dist_q),
		.done     (iter_done),
		.result   (iter_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				own_c_q[k] <= '0;
				own_n_q[k] <= '0;
			end
			csum_q <= '0;
			count_q <= '0;
			clip_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD_OWN: begin
					own_c_q[0] <= in_data[31:0];
					own_c_q[1] <= in_data[63:32];
					own_c_q[2] <= in_data[95:64];
					own_n_q[0] <= in_data[111:96];
					own_n_q[1] <= in_data[127:112];
					own_n_q[2] <= in_data[143:128];
					csum_q <= '0;
					count_q <= '0;
					clip_q <= 1'b0;
				end
				OP_DIV_DONE: begin
					if (iter_res[33:32] != 2'b00)
						clip_q <= 1'b1;
				end
				OP_ACCUM: begin
					csum_q <= csum_q + {16'd0, term_q};
					count_q <= (count_q == 2'(NEIGHBOURS - 1)) ? 2'd0 : count_q + 2'd1;
				end
				default: begin
				end
			endcase
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				csum_q <= '0;
				count_q <= '0;
				clip_q <= 1'b0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				nb_c_q[0] <= in_data[31:0];
				nb_c_q[1] <= in_data[63:32];
				nb_c_q[2] <= in_data[95:64];
				nb_n_q[0] <= in_data[111:96];
				nb_n_q[1] <= in_data[127:112];
				nb_n_q[2] <= in_data[143:128];
				sq_q <= '0;
				sum_q <= '0;
			end
			OP_SQUARE: begin
				sq_q <= 66'(dabs) * 66'(dabs);
				sum_q <= sum_q + sq_q;
			end
			OP_SQSUM: sum_q <= sum_q + sq_q;
			OP_DIST_START: begin
				if (dot > 34'sd268435456) begin
					dot_neg_q <= 1'b0;
					u_q <= ONE_Q28;
				end else if (dot < -34'sd268435456) begin
					dot_neg_q <= 1'b1;
					u_q <= ONE_Q28;
				end else begin
					dot_neg_q <= dot[33];
					u_q <= dot[33] ? 29'(-dot) : 29'(dot);
				end
				p_q <= acos_coef(2'd3);
			end
			OP_DIST_DONE: begin
				dist_q <= iter_res[32:0];
				term_q <= '0;
			end
			OP_HMUL: hprod_q <= p_q * $signed({1'b0, u_q});
			OP_HADD: begin
				if (cmd.idx == 2'd2 && p_next < 0)
					p_q <= '0;
				else
					p_q <= p_next;
			end
			OP_ACOS_DONE: s_q <= iter_res[28:0];
			OP_ACOS_MUL: aprod_q <= 60'(s_q) * 60'(p_q[30:0]);
			OP_ACOS_FIN: ac_q <= dot_neg_q ? PI_Q28 - a_val[29:0] : a_val[29:0];
			OP_DIV_DONE: term_q <= (iter_res[33:32] != 2'b00) ? WORD_MAX : iter_res[31:0];
			default: begin
			end
		endcase
		if (cmd.wmul)
			wprod_q <= 64'(gain) * 64'(csum_q);
		if (cmd.emit) begin
			out_weight_q <= (wsum[64:32] != 33'd0) ? WORD_MAX : wsum[31:0];
			out_sat_q <= clip_q || (wsum[64:32] != 33'd0);
		end
	end

	assign status.iter_done = iter_done;
	assign status.dist_zero = (dist_q == 33'd0);
	assign status.last = (count_q == 2'(NEIGHBOURS - 1));
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_weight = out_weight_q;
	assign out_sat = out_sat_q;

	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |-> status.out_free)
		else $error("result loaded over one not yet taken");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DIV_START |-> dist_q != 33'd0)
		else $error("division started with a zero distance");
	assert property (@(posedge clk) disable iff (!arst_n) count_q < 2'(NEIGHBOURS))
		else $error("neighbour count ran past the round length");

endmodule

/* rtl/fcw_ctrl.sv */
// Controller state machine that sequences the own-face load, one neighbour term and the weight output.
module fcw_ctrl
	import fcw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    in_func,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [16:0] {
		S_IDLE    = 17'h00001,
		S_SQ      = 17'h00002,
		S_SQSUM   = 17'h00004,
		S_DSTART  = 17'h00008,
		S_DWAIT   = 17'h00010,
		S_ZCHK    = 17'h00020,
		S_HMUL    = 17'h00040,
		S_HADD    = 17'h00080,
		S_ASTART  = 17'h00100,
		S_AWAIT   = 17'h00200,
		S_AMUL    = 17'h00400,
		S_AFIN    = 17'h00800,
		S_DVSTART = 17'h01000,
		S_DVWAIT  = 17'h02000,
		S_ACC     = 17'h04000,
		S_WMUL    = 17'h08000,
		S_EMIT    = 17'h10000
	} state_t;

	state_t     state_q, state_n;
	logic [1:0] idx_q, idx_n;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_n = state_q;
		idx_n = idx_q;
		cmd.op = OP_NONE;
		cmd.idx = idx_q;
		cmd.wmul = 1'b0;
		cmd.emit = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_func) begin
						cmd.op = OP_CAPTURE;
						idx_n = 2'd0;
						state_n = S_SQ;
					end else begin
						cmd.op = OP_LOAD_OWN;
					end
				end
			end
			S_SQ: begin
				cmd.op = OP_SQUARE;
				idx_n = idx_q + 2'd1;
				if (idx_q == 2'd2)
					state_n = S_SQSUM;
			end
			S_SQSUM: begin
				cmd.op = OP_SQSUM;
				state_n = S_DSTART;
			end
			S_DSTART: begin
				cmd.op = OP_DIST_START;
				state_n = S_DWAIT;
			end
			S_DWAIT: begin
				if (status.iter_done) begin
					cmd.op = OP_DIST_DONE;
					state_n = S_ZCHK;
				end
			end
			S_ZCHK: begin
				idx_n = 2'd0;
				state_n = status.dist_zero ? S_ACC : S_HMUL;
			end
			S_HMUL: begin
				cmd.op = OP_HMUL;
				state_n = S_HADD;
			end
			S_HADD: begin
				cmd.op = OP_HADD;
				idx_n = idx_q + 2'd1;
				state_n = (idx_q == 2'd2) ? S_ASTART : S_HMUL;
			end
			S_ASTART: begin
				cmd.op = OP_ACOS_START;
				state_n = S_AWAIT;
			end
			S_AWAIT: begin
				if (status.iter_done) begin
					cmd.op = OP_ACOS_DONE;
					state_n = S_AMUL;
				end
			end
			S_AMUL: begin
				cmd.op = OP_ACOS_MUL;
				state_n = S_AFIN;
			end
			S_AFIN: begin
				cmd.op = OP_ACOS_FIN;
				state_n = S_DVSTART;
			end
			S_DVSTART: begin
				cmd.op = OP_DIV_START;
				state_n = S_DVWAIT;
			end
			S_DVWAIT: begin
				if (status.iter_done) begin
					cmd.op = OP_DIV_DONE;
					state_n = S_ACC;
				end
			end
			S_ACC: begin
				cmd.op = OP_ACCUM;
				state_n = status.last ? S_WMUL : S_IDLE;
			end
			S_WMUL: begin
				cmd.wmul = 1'b1;
				state_n = S_EMIT;
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_n;
			idx_q <= idx_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("controller state is not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DSTART) |=> (state_q == S_DWAIT))
		else $error("distance root not awaited");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ACCUM && status.last) |=> (state_q == S_WMUL))
		else $error("last neighbour did not lead to the weight");

endmodule
